FILE: rtl/ntfsrd_pkg.sv
// Shared widths, phase codes, register indexes and the run record for the run-list decoder.
package ntfsrd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 64;
  localparam int unsigned BaseW   = 48;
  localparam int unsigned SpcW    = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgBaseSector       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSectorsPerCluster = 2'd1;

  localparam logic [BaseW-1:0] BaseSectorReset = '0;
  localparam logic [SpcW-1:0]  SpcReset        = 8'd8;

  typedef enum logic [1:0] {
    PH_DONE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_COUNT  = 2'd2,
    PH_OFFSET = 2'd3
  } phase_t;

  typedef struct packed {
    logic            clr;
    logic            eol;
    logic [SumW-1:0] count;
    logic [SumW-1:0] cluster;
  } run_t;

endpackage

FILE: rtl/ntfsrd_parse.sv
// Byte parser: header/count/offset tracking, cluster sum and the finished-run register.
module ntfsrd_parse
  import ntfsrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat_acc,
  input  logic [ByteW-1:0] run_byte,
  input  logic             start_of_list,
  input  logic             take,
  output logic             run_vld,
  output run_t             run
);

  function automatic logic [SumW-1:0] sext_off(input logic [SumW-1:0] v,
                                               input logic [PosW-1:0] len);
    logic [SumW-1:0] r;
    logic [5:0]      top;
    logic            sgn;
    r   = v;
    top = {len[2:0], 3'b000} - 6'd1;
    sgn = v[top];
    if (!len[3]) begin
      for (int k = 0; k < 8; k++) begin
        if (PosW'(k) >= len) r[8*k +: 8] = {8{sgn}};
      end
    end
    return r;
  endfunction

  phase_t          phase_r, phase_nxt;
  logic [PosW-1:0] left_r, left_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [PosW-1:0] olen_r, olen_nxt;
  logic [SumW-1:0] cnt_r, cnt_nxt;
  logic [SumW-1:0] off_r, off_nxt;
  logic [SumW-1:0] clus_r, clus_nxt;
  logic            pend_r, pend_nxt;
  logic            vld_r, vld_nxt;
  run_t            run_r, run_nxt;

  phase_t          phase_eff;
  logic [SumW-1:0] clus_eff;
  logic [SumW-1:0] byte_sh;
  logic [SumW-1:0] cnt_m;
  logic [SumW-1:0] off_m;
  logic [SumW-1:0] off_ext;
  logic [SumW-1:0] add_op;
  logic [SumW-1:0] clus_sum;
  logic [PosW-1:0] left_dec;
  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] hi_nib;
  logic [PosW-1:0] lo_nib;
  logic            emit;

  always_comb begin
    phase_eff = start_of_list ? PH_HEADER : phase_r;
    clus_eff  = start_of_list ? '0 : clus_r;
    byte_sh   = {{(SumW-ByteW){1'b0}}, run_byte} << {pos_r[2:0], 3'b000};
    cnt_m     = pos_r[3] ? cnt_r : (cnt_r | byte_sh);
    off_m     = pos_r[3] ? off_r : (off_r | byte_sh);
    off_ext   = sext_off(off_m, olen_r);
    add_op    = (phase_eff == PH_OFFSET) ? off_ext : off_r;
    clus_sum  = clus_eff + add_op;
    left_dec  = left_r - 1'b1;
    pos_inc   = pos_r + 1'b1;
    lo_nib    = run_byte[3:0];
    hi_nib    = run_byte[7:4];

    phase_nxt = phase_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    olen_nxt  = olen_r;
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    clus_nxt  = clus_r;
    pend_nxt  = pend_r;
    emit      = 1'b0;
    run_nxt   = run_r;

    if (beat_acc) begin
      clus_nxt = clus_eff;
      pend_nxt = pend_r | start_of_list;
      unique case (phase_eff)
        PH_HEADER: begin
          if (run_byte == '0) begin
            emit        = 1'b1;
            run_nxt.eol = 1'b1;
            run_nxt.count   = '0;
            run_nxt.cluster = '0;
            phase_nxt   = PH_DONE;
          end else begin
            cnt_nxt  = '0;
            off_nxt  = '0;
            pos_nxt  = '0;
            olen_nxt = hi_nib;
            if (lo_nib != '0) begin
              left_nxt  = lo_nib;
              phase_nxt = PH_COUNT;
            end else begin
              left_nxt  = hi_nib;
              phase_nxt = PH_OFFSET;
            end
          end
        end
        PH_COUNT: begin
          cnt_nxt  = cnt_m;
          pos_nxt  = pos_inc;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            if (olen_r == '0) begin
              emit            = 1'b1;
              run_nxt.eol     = 1'b0;
              run_nxt.count   = cnt_m;
              run_nxt.cluster = clus_sum;
              clus_nxt        = clus_sum;
              phase_nxt       = PH_HEADER;
            end else begin
              pos_nxt   = '0;
              left_nxt  = olen_r;
              phase_nxt = PH_OFFSET;
            end
          end
        end
        PH_OFFSET: begin
          off_nxt  = off_m;
          pos_nxt  = pos_inc;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            off_nxt         = off_ext;
            emit            = 1'b1;
            run_nxt.eol     = 1'b0;
            run_nxt.count   = cnt_r;
            run_nxt.cluster = clus_sum;
            clus_nxt        = clus_sum;
            phase_nxt       = PH_HEADER;
          end
        end
        PH_DONE: begin
        end
      endcase
      if (emit) begin
        run_nxt.clr = pend_r | start_of_list;
        pend_nxt    = 1'b0;
      end
    end

    if (beat_acc && emit) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      left_r  <= '0;
      pos_r   <= '0;
      olen_r  <= '0;
      cnt_r   <= '0;
      off_r   <= '0;
      clus_r  <= '0;
      pend_r  <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      olen_r  <= olen_nxt;
      cnt_r   <= cnt_nxt;
      off_r   <= off_nxt;
      clus_r  <= clus_nxt;
      pend_r  <= pend_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  assign run_vld = vld_r;
  assign run     = run_r;

endmodule

FILE: rtl/ntfs_data_run_decoder_core.sv
// Top level of the run-list decoder: parser, scaling multiply stage and output register.
//
//   channel  dir  ports                          payload (low bit up)
//   in       in   in_tvalid/in_tready            in_tdata: run_byte; in_tuser: start_of_list
//   out      out  out_tvalid/out_tready          out_tdata: run_start_sector, run_sectors,
//                                                dest_sector_offset; out_tlast: end_of_list
//   cfg      in   cfg_we/cfg_idx/cfg_wdata       0 base_sector, 1 sectors_per_cluster
//
// One byte is taken every cycle while in_tready is high. After its last byte a result passes
// the parser register, multiply register (two 64x8 products) and output register (base and
// destination adds). Reset is synchronous. Stalls on out back up through the three
// registers; in_tready drops only when all of them are full.
module ntfs_data_run_decoder_core
  import ntfsrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ByteW-1:0]     in_tdata,    // [7:0] run_byte
  input  logic                 in_tuser,    // [0] start_of_list
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3*SumW-1:0]    out_tdata,   // [63:0] run_start_sector, [127:64] run_sectors,
                                            // [191:128] dest_sector_offset
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_idx,
  input  logic [BaseW-1:0]     cfg_wdata
);

  logic [BaseW-1:0] base_r;
  logic [SpcW-1:0]  spc_r;

  logic             a_vld;
  run_t             a_run;
  logic             a_take;
  logic             beat_acc;

  logic             b_vld_r, b_vld_nxt;
  logic [SumW-1:0]  secs_r, secs_nxt;
  logic [SumW-1:0]  prod_r, prod_nxt;
  logic             b_clr_r, b_clr_nxt;
  logic             b_eol_r, b_eol_nxt;
  logic             b_ready;
  logic             b_take;

  logic             o_vld_r, o_vld_nxt;
  logic [3*SumW-1:0] o_data_r, o_data_nxt;
  logic             o_last_r, o_last_nxt;
  logic             o_ready;
  logic [SumW-1:0]  dest_r, dest_nxt;
  logic [SumW-1:0]  dest_base;
  logic [SumW-1:0]  spc_ext;

  assign o_ready   = !o_vld_r || out_tready;
  assign b_take    = b_vld_r && o_ready;
  assign b_ready   = !b_vld_r || b_take;
  assign a_take    = a_vld && b_ready;
  assign in_tready = !a_vld || a_take;
  assign beat_acc  = in_tvalid && in_tready;

  ntfsrd_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_acc      (beat_acc),
    .run_byte      (in_tdata),
    .start_of_list (in_tuser),
    .take          (a_take),
    .run_vld       (a_vld),
    .run           (a_run)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BaseSectorReset;
      spc_r  <= SpcReset;
    end else if (cfg_we) begin
      if (cfg_idx == CfgBaseSector) begin
        base_r <= cfg_wdata;
      end else if (cfg_idx == CfgSectorsPerCluster) begin
        spc_r <= cfg_wdata[SpcW-1:0];
      end
    end
  end

  assign spc_ext = {{(SumW-SpcW){1'b0}}, spc_r};

  always_comb begin
    secs_nxt  = secs_r;
    prod_nxt  = prod_r;
    b_clr_nxt = b_clr_r;
    b_eol_nxt = b_eol_r;
    if (a_take) begin
      secs_nxt  = a_run.count * spc_ext;
      prod_nxt  = a_run.cluster * spc_ext;
      b_clr_nxt = a_run.clr;
      b_eol_nxt = a_run.eol;
    end
    if (a_take) begin
      b_vld_nxt = 1'b1;
    end else if (b_take) begin
      b_vld_nxt = 1'b0;
    end else begin
      b_vld_nxt = b_vld_r;
    end
  end

  always_comb begin
    dest_base  = b_clr_r ? '0 : dest_r;
    dest_nxt   = dest_r;
    o_data_nxt = o_data_r;
    o_last_nxt = o_last_r;
    if (b_take) begin
      dest_nxt = dest_base + secs_r;
      if (b_eol_r) begin
        o_data_nxt = '0;
      end else begin
        o_data_nxt = {dest_base, secs_r, {{(SumW-BaseW){1'b0}}, base_r} + prod_r};
      end
      o_last_nxt = b_eol_r;
    end
    if (b_take) begin
      o_vld_nxt = 1'b1;
    end else if (out_tready) begin
      o_vld_nxt = 1'b0;
    end else begin
      o_vld_nxt = o_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
      dest_r  <= '0;
    end else begin
      b_vld_r <= b_vld_nxt;
      o_vld_r <= o_vld_nxt;
      dest_r  <= dest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    secs_r   <= secs_nxt;
    prod_r   <= prod_nxt;
    b_clr_r  <= b_clr_nxt;
    b_eol_r  <= b_eol_nxt;
    o_data_r <= o_data_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;

endmodule

FILE: rtl/ntfsrd_chk.sv
// Port-level checks for the run-list decoder, bound to the top level.
module ntfsrd_chk
  import ntfsrd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [3*SumW-1:0] out_tdata,
  input logic              out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("out beat changed while stalled");

  a_eol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == '0)
    else $error("end-of-list beat carries nonzero fields");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind ntfs_data_run_decoder_core ntfsrd_chk u_ntfsrd_chk (.*);
